// ----- rtl/core/scara_ik_pkg.sv -----
// scara_ik_pkg: shared types and constants for the scara inverse kinematics block
// used by the controller, the datapath and the top level
package scara_ik_pkg;

   localparam int FieldWidth = 17;
   localparam int AtabLen    = 24;
   localparam int AccWidth   = 34;

   typedef enum logic [1:0] {
      OP_SOLVE        = 2'd0,
      OP_SOLVE_COMMIT = 2'd1,
      OP_LOAD         = 2'd2,
      OP_SOLVE_ALT    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_UP_CHOSEN   = 3'd0,
      ST_DOWN_CHOSEN = 3'd1,
      ST_ONLY_UP     = 3'd2,
      ST_ONLY_DOWN   = 3'd3,
      ST_NONE        = 3'd4,
      ST_LOADED      = 3'd5
   } status_type;

   // arctangent table, degrees times 2^20
   function automatic logic signed [31:0] atab(input logic [4:0] idx);
      logic signed [31:0] v;
      begin
         v = '0;
         case (idx)
            5'd0:  v = 32'sd47185920;
            5'd1:  v = 32'sd27855475;
            5'd2:  v = 32'sd14718068;
            5'd3:  v = 32'sd7471121;
            5'd4:  v = 32'sd3750058;
            5'd5:  v = 32'sd1876857;
            5'd6:  v = 32'sd938658;
            5'd7:  v = 32'sd469357;
            5'd8:  v = 32'sd234682;
            5'd9:  v = 32'sd117342;
            5'd10: v = 32'sd58671;
            5'd11: v = 32'sd29335;
            5'd12: v = 32'sd14668;
            5'd13: v = 32'sd7334;
            5'd14: v = 32'sd3667;
            5'd15: v = 32'sd1833;
            5'd16: v = 32'sd917;
            5'd17: v = 32'sd458;
            5'd18: v = 32'sd229;
            5'd19: v = 32'sd115;
            5'd20: v = 32'sd57;
            5'd21: v = 32'sd29;
            5'd22: v = 32'sd14;
            5'd23: v = 32'sd7;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

   // controller to datapath
   typedef struct packed {
      logic load_in;      // capture request word
      logic sq_x;         // multiply x*x
      logic sq_y;         // multiply y*y, sum into r2
      logic prep;         // compute factors
      logic mul_q;        // start q multiply
      logic sqrt_start;
      logic sqrt_step;
      logic cor_start;    // start atan2
      logic [1:0] cor_sel; // 0 base, 1 offset, 2 elbow
      logic cor_step;
      logic cor_done;     // store result
      logic assemble;
      logic chg_step;
      logic [2:0] chg_idx;
      logic decide;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic short_reach;
      logic stretched;
      logic is_load;
   } stat_type;

endpackage

// ----- rtl/core/scara_ik_ctrl.sv -----
// scara_ik_ctrl: sequencer for the scara inverse kinematics datapath
// depends on scara_ik_pkg
module scara_ik_ctrl #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  scara_ik_pkg::stat_type  stat,
   output scara_ik_pkg::cmd_type   cmd
);
   import scara_ik_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_SQX    = 12'b000000000010,
      S_SQY    = 12'b000000000100,
      S_PREP   = 12'b000000001000,
      S_MULQ   = 12'b000000010000,
      S_SQRT   = 12'b000000100000,
      S_CORINI = 12'b000001000000,
      S_COR    = 12'b000010000000,
      S_ASM    = 12'b000100000000,
      S_CHG    = 12'b001000000000,
      S_DEC    = 12'b010000000000,
      S_OUT    = 12'b100000000000
   } state_type;

   localparam int CntW = 6;

   state_type state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;
   logic rsp_valid_ff, rsp_valid_in;

   // the result registers stay untouched while a word waits
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sel_in = sel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      cmd.cor_sel = sel_ff;
      cmd.chg_idx = cnt_ff[2:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               cmd.load_in = 1'b1;
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            if (stat.is_load) begin
               cmd.commit = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.sq_x = 1'b1;
               state_in = S_SQY;
            end
         end
         S_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            sel_in = 2'd0;
            if (stat.short_reach) begin
               state_in = S_DEC;
            end else if (stat.stretched) begin
               state_in = S_CORINI;
            end else begin
               state_in = S_MULQ;
            end
         end
         S_MULQ: begin
            cmd.mul_q = 1'b1;
            cmd.sqrt_start = 1'b1;
            cnt_in = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(31)) begin
               sel_in = 2'd1;
               state_in = S_CORINI;
            end
         end
         S_CORINI: begin
            cmd.cor_start = 1'b1;
            cnt_in = '0;
            state_in = S_COR;
         end
         S_COR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(CORDIC_ITERATIONS)) begin
               cmd.cor_done = 1'b1;
               // order: offset, elbow, base
               if (sel_ff == 2'd1) begin
                  sel_in = 2'd2;
                  state_in = S_CORINI;
               end else if (sel_ff == 2'd2) begin
                  sel_in = 2'd0;
                  state_in = S_CORINI;
               end else begin
                  state_in = S_ASM;
               end
            end else begin
               cmd.cor_step = 1'b1;
            end
         end
         S_ASM: begin
            cmd.assemble = 1'b1;
            cnt_in = '0;
            state_in = S_CHG;
         end
         S_CHG: begin
            cmd.chg_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(7)) state_in = S_DEC;
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         sel_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sel_ff <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ----- rtl/core/scara_ik_dp.sv -----
// scara_ik_dp: datapath with r^2, square root, shared cordic atan2 and selection
// depends on scara_ik_pkg
module scara_ik_dp #(
   parameter int ANGLE_FRAC_BITS   = 8,
   parameter int LENGTH_FRAC_BITS  = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  scara_ik_pkg::cmd_type               cmd,
   output scara_ik_pkg::stat_type              stat,
   input  logic [1:0]                          req_op,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_target_x,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_target_y,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_target_z,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_target_phi,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_load_joint1,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_load_joint2,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_load_joint3,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_load_joint4,
   output logic signed [scara_ik_pkg::FieldWidth-1:0] rsp_sol_joint1,
   output logic signed [scara_ik_pkg::FieldWidth-1:0] rsp_sol_joint2,
   output logic signed [scara_ik_pkg::FieldWidth-1:0] rsp_sol_joint3,
   output logic signed [scara_ik_pkg::FieldWidth-1:0] rsp_sol_joint4,
   output logic [2:0]                          rsp_status
);
   import scara_ik_pkg::*;

   localparam int FW   = FieldWidth;
   localparam int LF2  = 2 * LENGTH_FRAC_BITS;
   localparam int SH   = (LF2 > 14) ? LF2 - 14 : 0;
   localparam int E    = LF2 - SH;
   localparam int RW   = 40;   // r^2 width
   localparam int FACW = 32;   // factors after truncation
   localparam int QW   = 64;
   localparam int SW   = 32;
   localparam int CW   = 40;   // cordic vector width
   localparam int AF   = 20;
   localparam int AOUT = AF - ANGLE_FRAC_BITS;
   localparam int HALF = 180 << ANGLE_FRAC_BITS;
   // joint sums before wrapping reach about three half turns plus a field
   localparam int AW   = (ANGLE_FRAC_BITS + 11 > FW + 3) ? ANGLE_FRAC_BITS + 11 : FW + 3;
   localparam int LW   = AW + 14; // change compare width
   localparam logic [RW-1:0] Lo2 = RW'(64'd2809 << LF2);
   localparam logic [RW-1:0] Hi2 = RW'(64'd113569 << LF2);
   localparam logic signed [FACW:0] KLo = (FACW+1)'(64'd2809 << E);
   localparam logic signed [FACW:0] KHi = (FACW+1)'(64'd113569 << E);
   localparam logic signed [FACW:0] KC1 = (FACW+1)'(64'd17861 << E);
   localparam logic signed [FACW:0] KC2 = (FACW+1)'(64'd58189 << E);
   localparam logic signed [AW-1:0] L1 = AW'(150 << ANGLE_FRAC_BITS);
   localparam logic signed [AW-1:0] L2 = AW'(100 << ANGLE_FRAC_BITS);
   localparam logic signed [AW-1:0] L4 = AW'(160 << ANGLE_FRAC_BITS);
   localparam logic signed [AW-1:0] J3Lo = -AW'(200 << LENGTH_FRAC_BITS);
   localparam logic signed [AW-1:0] J3Hi = -AW'(100 << LENGTH_FRAC_BITS);
   localparam logic signed [AW-1:0] ZOff = AW'(75 << LENGTH_FRAC_BITS);
   localparam logic [QW-1:0] SqrtTop = QW'(1) << (QW - 2);

   // request word
   logic [1:0] op_ff;
   logic signed [FW-1:0] x_ff, y_ff, z_ff, phi_ff;
   logic signed [FW-1:0] ld_ff [4];
   logic signed [FW-1:0] cur_ff [4];

   // r^2 and factors
   logic [RW-1:0] prod_ff, r2_ff;
   logic signed [FACW:0] f1_ff, f2_ff, c1_ff, c2_ff;
   logic [QW-1:0] q_ff;
   logic [QW-1:0] rem_ff, res_ff, bit_ff;

   // cordic
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [AccWidth-1:0] acc_ff;
   logic [4:0] it_ff;
   logic signed [AW-1:0] off_ff, elb_ff, xy_ff;

   // candidates
   logic signed [AW-1:0] up_ff [4];
   logic signed [AW-1:0] dn_ff [4];
   logic [LW-1:0] mu_ff, md_ff;
   logic signed [FW-1:0] sol_ff [4];
   logic [2:0] status_ff;

   logic signed [FW-1:0] mul_a;
   logic signed [2*FW-1:0] mul_p;

   always_comb begin
      mul_a = cmd.sq_x ? x_ff : y_ff;
      mul_p = mul_a * mul_a;
   end

   assign stat.is_load     = (op_ff == OP_LOAD);
   assign stat.short_reach = (r2_ff < Lo2);
   assign stat.stretched   = (r2_ff >= Hi2);

   // square root, one bit pair per cycle; the first step works on q itself
   logic [QW-1:0] trial, rem_cur;
   assign trial = res_ff + bit_ff;
   assign rem_cur = (bit_ff == SqrtTop) ? q_ff : rem_ff;

   // cordic start vector
   logic signed [CW-1:0] sx, sy, px, py;
   logic signed [AccWidth-1:0] pacc;
   always_comb begin
      case (cmd.cor_sel)
         2'd1: begin
            sy = CW'($signed({1'b0, res_ff[SW-1:0]}));
            sx = CW'(c1_ff);
         end
         2'd2: begin
            sy = CW'($signed({1'b0, res_ff[SW-1:0]}));
            sx = CW'(c2_ff);
         end
         default: begin
            sy = CW'(y_ff);
            sx = CW'(x_ff);
         end
      endcase
      px = sx;
      py = sy;
      pacc = '0;
      if (sx < 0) begin
         if (sy >= 0) begin
            px = sy; py = -sx; pacc = AccWidth'(90 <<< AF);
         end else begin
            px = -sy; py = sx; pacc = -AccWidth'(90 <<< AF);
         end
      end
   end

   logic signed [CW-1:0] dx, dy;
   assign dx = cy_ff >>> it_ff;
   assign dy = cx_ff >>> it_ff;

   logic signed [AccWidth-1:0] rnd;
   logic signed [AW-1:0] ang;
   logic zero_vec;
   assign rnd = (acc_ff + (AccWidth'(1) <<< (AOUT - 1))) >>> AOUT;
   assign ang = zero_vec ? '0 : AW'(rnd);

   function automatic logic signed [AW-1:0] wrap(input logic signed [AW-1:0] v);
      begin
         if (v < -AW'(HALF)) return v + AW'(2 * HALF);
         else if (v > AW'(HALF)) return v - AW'(2 * HALF);
         else return v;
      end
   endfunction

   function automatic logic [AW-1:0] absv(input logic signed [AW-1:0] v);
      begin
         return v[AW-1] ? AW'(-v) : AW'(v);
      end
   endfunction

   function automatic logic ok(input logic signed [AW-1:0] j0,
                               input logic signed [AW-1:0] j1,
                               input logic signed [AW-1:0] j2,
                               input logic signed [AW-1:0] j3);
      begin
         return ($signed(absv(j0)) < L1) && ($signed(absv(j1)) < L2) &&
                (j2 > J3Lo) && (j2 < J3Hi) && ($signed(absv(j3)) < L4);
      end
   endfunction

   // per-joint change, one joint per cycle for up then down
   logic signed [AW-1:0] cj, dj;
   logic [AW-1:0] ad;
   logic [LW-1:0] sc;
   always_comb begin
      cj = AW'(cur_ff[cmd.chg_idx[1:0]]);
      dj = cmd.chg_idx[2] ? dn_ff[cmd.chg_idx[1:0]] : up_ff[cmd.chg_idx[1:0]];
      ad = absv(cj - dj);
      if (cmd.chg_idx[1:0] == 2'd2) sc = LW'(ad) << ANGLE_FRAC_BITS;
      else sc = LW'(ad) << LENGTH_FRAC_BITS;
   end

   logic vu, vd;
   assign vu = ok(up_ff[0], up_ff[1], up_ff[2], up_ff[3]);
   assign vd = ok(dn_ff[0], dn_ff[1], dn_ff[2], dn_ff[3]);

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff <= req_op;
         x_ff <= req_target_x;
         y_ff <= req_target_y;
         z_ff <= req_target_z;
         phi_ff <= req_target_phi;
         ld_ff[0] <= req_load_joint1;
         ld_ff[1] <= req_load_joint2;
         ld_ff[2] <= req_load_joint3;
         ld_ff[3] <= req_load_joint4;
      end
      if (cmd.sq_x) prod_ff <= RW'(unsigned'(mul_p));
      if (cmd.sq_y) r2_ff <= prod_ff + RW'(unsigned'(mul_p));
      if (cmd.prep) begin
         f1_ff <= (FACW+1)'(r2_ff >> SH) - KLo;
         f2_ff <= KHi - (FACW+1)'(r2_ff >> SH);
         c1_ff <= (FACW+1)'(r2_ff >> SH) + KC1;
         c2_ff <= (FACW+1)'(r2_ff >> SH) - KC2;
         off_ff <= '0;
         elb_ff <= '0;
      end
      // both factors are below 2^32 whenever the triangle exists
      if (cmd.mul_q) q_ff <= QW'(f1_ff[FACW-1:0]) * QW'(f2_ff[FACW-1:0]);
      if (cmd.sqrt_start) begin
         res_ff <= '0;
         bit_ff <= SqrtTop;
      end
      if (cmd.sqrt_step) begin
         if (rem_cur >= trial) begin
            rem_ff <= rem_cur - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            rem_ff <= rem_cur;
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.cor_start) begin
         cx_ff <= px;
         cy_ff <= py;
         acc_ff <= pacc;
         it_ff <= '0;
         zero_vec <= (sx == 0) && (sy == 0);
      end
      if (cmd.cor_step) begin
         if (cy_ff >= 0) begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            acc_ff <= acc_ff + AccWidth'(atab(it_ff));
         end else begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            acc_ff <= acc_ff - AccWidth'(atab(it_ff));
         end
         it_ff <= it_ff + 1'b1;
      end
      if (cmd.cor_done) begin
         case (cmd.cor_sel)
            2'd1: off_ff <= ang;
            2'd2: elb_ff <= ang;
            default: xy_ff <= ang;
         endcase
      end
      if (cmd.assemble) begin
         up_ff[0] <= wrap(xy_ff - off_ff);
         dn_ff[0] <= wrap(xy_ff + off_ff);
         up_ff[1] <= elb_ff;
         dn_ff[1] <= -elb_ff;
         up_ff[2] <= -ZOff - AW'(z_ff);
         dn_ff[2] <= -ZOff - AW'(z_ff);
         up_ff[3] <= wrap(-AW'(phi_ff) + xy_ff - off_ff + elb_ff);
         dn_ff[3] <= wrap(-AW'(phi_ff) + xy_ff + off_ff - elb_ff);
         mu_ff <= '0;
         md_ff <= '0;
      end
      if (cmd.chg_step) begin
         if (cmd.chg_idx[2]) begin
            if (sc > md_ff) md_ff <= sc;
         end else begin
            if (sc > mu_ff) mu_ff <= sc;
         end
      end
      if (cmd.decide) begin
         if (!stat.short_reach && vu && (!vd || mu_ff < md_ff)) begin
            status_ff <= vd ? ST_UP_CHOSEN : ST_ONLY_UP;
            for (int k = 0; k < 4; k++) sol_ff[k] <= FW'(up_ff[k]);
            if (op_ff == OP_SOLVE_COMMIT)
               for (int k = 0; k < 4; k++) cur_ff[k] <= FW'(up_ff[k]);
         end else if (!stat.short_reach && vd) begin
            status_ff <= vu ? ST_DOWN_CHOSEN : ST_ONLY_DOWN;
            for (int k = 0; k < 4; k++) sol_ff[k] <= FW'(dn_ff[k]);
            if (op_ff == OP_SOLVE_COMMIT)
               for (int k = 0; k < 4; k++) cur_ff[k] <= FW'(dn_ff[k]);
         end else begin
            status_ff <= ST_NONE;
            for (int k = 0; k < 4; k++) sol_ff[k] <= '0;
         end
      end
      if (cmd.commit) begin
         status_ff <= ST_LOADED;
         for (int k = 0; k < 4; k++) begin
            sol_ff[k] <= ld_ff[k];
            cur_ff[k] <= ld_ff[k];
         end
      end
      if (reset) begin
         for (int k = 0; k < 4; k++) cur_ff[k] <= '0;
      end
   end

   assign rsp_sol_joint1 = sol_ff[0];
   assign rsp_sol_joint2 = sol_ff[1];
   assign rsp_sol_joint3 = sol_ff[2];
   assign rsp_sol_joint4 = sol_ff[3];
   assign rsp_status = status_ff;
endmodule

// ----- rtl/core/scara_inverse_kinematics.sv -----
// scara inverse kinematics: one item at a time. a solve runs a setup of squaring x and y,
// forming the factors and the triangle term, a bit-pair square root on that term, three
// atan2 runs (offset, elbow, base) on one shared cordic unit, a largest-change compare over
// the joints of both candidates, and a decide step before the word is presented. at full
// stretch the root and two atan2 runs are skipped, a short reach goes straight to the
// decide step and a load straight to the word. the result word sits in an output register
// until taken; the next request is accepted in the cycle after the word is taken.
// depends on scara_ik_pkg, scara_ik_ctrl, scara_ik_dp
module scara_inverse_kinematics #(
   parameter int ANGLE_FRAC_BITS   = 8,
   parameter int LENGTH_FRAC_BITS  = 6,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_op,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_target_x,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_target_y,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_target_z,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_target_phi,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_load_joint1,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_load_joint2,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_load_joint3,
   input  logic signed [scara_ik_pkg::FieldWidth-1:0] req_load_joint4,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [scara_ik_pkg::FieldWidth-1:0] rsp_sol_joint1,
   output logic signed [scara_ik_pkg::FieldWidth-1:0] rsp_sol_joint2,
   output logic signed [scara_ik_pkg::FieldWidth-1:0] rsp_sol_joint3,
   output logic signed [scara_ik_pkg::FieldWidth-1:0] rsp_sol_joint4,
   output logic [2:0] rsp_status
);
   import scara_ik_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   scara_ik_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .cmd
   );

   scara_ik_dp #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .LENGTH_FRAC_BITS(LENGTH_FRAC_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .stat, .req_op, .req_target_x, .req_target_y,
      .req_target_z, .req_target_phi, .req_load_joint1, .req_load_joint2,
      .req_load_joint3, .req_load_joint4, .rsp_sol_joint1, .rsp_sol_joint2,
      .rsp_sol_joint3, .rsp_sol_joint4, .rsp_status
   );

   // a word is never handed over while a request is being taken
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall && rsp_valid && !rsp_stall))
      else $error("request taken while result pending");

   // status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= 3'd5))
      else $error("bad status");

   // no solution gives zero on joints one and four
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == 3'd4) |-> (rsp_sol_joint1 == '0 && rsp_sol_joint4 == '0))
      else $error("nonzero joints without solution");
endmodule
